@@ sv/tmbs_pkg.sv @@
// Shared types and constants for the terrain material blend select block.
// No dependencies; used by every module of the block.
package tmbs_pkg;

    localparam int WW     = 17;                  // Q1.16 weight, 1.0 held exactly
    localparam int DIV_W  = 26;                  // share numerator / shifted divisor
    localparam int REM_W  = DIV_W + 1;

    localparam logic [WW-1:0] W_ONE    = 17'd65536;
    localparam logic [WW-1:0] SAND_MIN = 17'd131;   // 0.002
    localparam logic [17:0]   D_MIN    = 18'd7;     // 1e-4

    localparam logic signed [20:0] STEEP_OFS = 21'sd144179;   // 0.55 * 16 * 2^14
    localparam logic signed [20:0] STEEP_MAX = 21'sd65536;

    // high = trunc(x * 512 / 25), x = height - 34.0, saturates above x = 3200
    localparam logic signed [24:0] HIGH_BASE  = 25'sd8704;
    localparam logic signed [24:0] HIGH_SPAN  = 25'sd3200;
    localparam logic [21:0]        HIGH_RECIP = 22'd2684355;  // ceil(2^26 / 25)

    localparam logic signed [25:0] GH_OFS    = 26'sd768;
    localparam logic signed [25:0] GH_SPAN   = 26'sd2048;
    localparam logic signed [25:0] SAND_OFS  = 26'sd512;
    localparam logic signed [25:0] SAND_SPAN = 26'sd512;

    localparam logic [7:0] DOM_MIN = 8'd128;

    typedef enum logic [1:0] {
        LAYER_GRASS = 2'd0,
        LAYER_DIRT  = 2'd1,
        LAYER_ROCK  = 2'd2,
        LAYER_SAND  = 2'd3
    } layer_t;

    typedef struct packed {
        layer_t     p;
        layer_t     q;
        logic       sand_hit;
        logic [7:0] sand_pw;
        logic [7:0] e1;
        logic [7:0] e2;
        logic [7:0] ew;
    } side_t;

    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [DIV_W-1:0] dsh;
        logic [7:0]       quo;
    } div_t;

endpackage

@@ sv/tmbs_weights.sv @@
// Procedural layer weights: steepness, altitude, grass/dirt split and sand ramp.
// Four register stages. Depends on tmbs_pkg.
module tmbs_weights
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_vld,
    input  logic signed [23:0]        height,
    input  logic signed [15:0]        slope,
    input  logic signed [23:0]        sea_level,
    input  logic [7:0]                edit_index_first,
    input  logic [7:0]                edit_index_second,
    input  logic [7:0]                edit_weight,
    output logic                      w_vld,
    output logic [tmbs_pkg::WW-1:0]   grass,
    output logic [tmbs_pkg::WW-1:0]   dirt,
    output logic [tmbs_pkg::WW-1:0]   rock,
    output tmbs_pkg::side_t           w_side
);

    // stage 1
    logic signed [20:0]          steep_arg;
    logic [tmbs_pkg::WW-1:0]     steep_sat;
    logic signed [24:0]          hx;
    logic [33:0]                 high_prod;
    logic signed [25:0]          gh_arg;
    logic signed [25:0]          sand_arg;
    logic [tmbs_pkg::WW-1:0]     steep_next, high_next, gh_next, sand_next;
    tmbs_pkg::side_t             side1_next;

    logic                        s1_vld_reg;
    logic [tmbs_pkg::WW-1:0]     s1_steep_reg, s1_high_reg, s1_gh_reg, s1_sand_reg;
    tmbs_pkg::side_t             s1_side_reg;

    always_comb
    begin
        steep_arg = {slope[15], slope, 4'b0000} - tmbs_pkg::STEEP_OFS;
        if (steep_arg < 21'sd0)
            steep_sat = '0;
        else if (steep_arg > tmbs_pkg::STEEP_MAX)
            steep_sat = tmbs_pkg::W_ONE;
        else
            steep_sat = steep_arg[16:0];
        steep_next = tmbs_pkg::W_ONE - steep_sat;

        hx        = {height[23], height} - tmbs_pkg::HIGH_BASE;
        high_prod = 34'(hx[11:0]) * 34'(tmbs_pkg::HIGH_RECIP);
        if (hx <= 25'sd0)
            high_next = '0;
        else if (hx > tmbs_pkg::HIGH_SPAN)
            high_next = tmbs_pkg::W_ONE;
        else
            high_next = high_prod[33:17];

        gh_arg = {{2{height[23]}}, height} - {{2{sea_level[23]}}, sea_level}
                 - tmbs_pkg::GH_OFS;
        if (gh_arg <= 26'sd0)
            gh_next = '0;
        else if (gh_arg > tmbs_pkg::GH_SPAN)
            gh_next = tmbs_pkg::W_ONE;
        else
            gh_next = {gh_arg[11:0], 5'b00000};

        sand_arg = {{2{sea_level[23]}}, sea_level} + tmbs_pkg::SAND_OFS
                   - {{2{height[23]}}, height};
        if (sand_arg <= 26'sd0)
            sand_next = '0;
        else if (sand_arg > tmbs_pkg::SAND_SPAN)
            sand_next = tmbs_pkg::W_ONE;
        else
            sand_next = {sand_arg[9:0], 7'b0000000};

        side1_next.p        = tmbs_pkg::LAYER_GRASS;
        side1_next.q        = tmbs_pkg::LAYER_DIRT;
        side1_next.sand_hit = 1'b0;
        side1_next.sand_pw  = '0;
        side1_next.e1       = edit_index_first;
        side1_next.e2       = edit_index_second;
        side1_next.ew       = edit_weight;
    end

    // stage 2
    logic [tmbs_pkg::WW-1:0]     rock2_next, nr2_next;
    logic [24:0]                 sand_scaled;
    tmbs_pkg::side_t             side2_next;

    logic                        s2_vld_reg;
    logic [tmbs_pkg::WW-1:0]     s2_rock_reg, s2_nr_reg, s2_gh_reg;
    tmbs_pkg::side_t             s2_side_reg;

    always_comb
    begin
        rock2_next  = (s1_steep_reg > s1_high_reg) ? s1_steep_reg : s1_high_reg;
        nr2_next    = tmbs_pkg::W_ONE - rock2_next;
        sand_scaled = {s1_sand_reg, 8'b0} - 25'(s1_sand_reg) + 25'd32768;
        side2_next  = s1_side_reg;
        side2_next.sand_hit = s1_sand_reg > tmbs_pkg::SAND_MIN;
        side2_next.sand_pw  = (sand_scaled[24:16] > 9'd255) ? 8'd255 : sand_scaled[23:16];
    end

    // stage 3
    logic [33:0]                 ga_prod;

    logic                        s3_vld_reg;
    logic [tmbs_pkg::WW-1:0]     s3_ga_reg, s3_nr_reg, s3_rock_reg;
    tmbs_pkg::side_t             s3_side_reg;

    assign ga_prod = 34'(s2_nr_reg) * 34'(s2_gh_reg) + 34'd32768;

    // stage 4
    logic [33:0]                 grass_prod, dirt_prod;
    logic [tmbs_pkg::WW-1:0]     ga_inv;

    logic                        s4_vld_reg;
    logic [tmbs_pkg::WW-1:0]     s4_grass_reg, s4_dirt_reg, s4_rock_reg;
    tmbs_pkg::side_t             s4_side_reg;

    always_comb
    begin
        ga_inv     = tmbs_pkg::W_ONE - s3_ga_reg;
        grass_prod = 34'(s3_ga_reg) * 34'(s3_nr_reg) + 34'd32768;
        dirt_prod  = 34'(ga_inv) * 34'(s3_nr_reg) + 34'd32768;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= in_vld;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_steep_reg <= steep_next;
        s1_high_reg  <= high_next;
        s1_gh_reg    <= gh_next;
        s1_sand_reg  <= sand_next;
        s1_side_reg  <= side1_next;

        s2_rock_reg  <= rock2_next;
        s2_nr_reg    <= nr2_next;
        s2_gh_reg    <= s1_gh_reg;
        s2_side_reg  <= side2_next;

        s3_ga_reg    <= ga_prod[32:16];
        s3_nr_reg    <= s2_nr_reg;
        s3_rock_reg  <= s2_rock_reg;
        s3_side_reg  <= s2_side_reg;

        s4_grass_reg <= grass_prod[32:16];
        s4_dirt_reg  <= dirt_prod[32:16];
        s4_rock_reg  <= s3_rock_reg;
        s4_side_reg  <= s3_side_reg;
    end

    assign w_vld  = s4_vld_reg;
    assign grass  = s4_grass_reg;
    assign dirt   = s4_dirt_reg;
    assign rock   = s4_rock_reg;
    assign w_side = s4_side_reg;

endmodule

@@ sv/tmbs_select.sv @@
// Picks the two strongest layers and sets up the primary-share division.
// Two register stages. Depends on tmbs_pkg.
module tmbs_select
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      w_vld,
    input  logic [tmbs_pkg::WW-1:0]   grass,
    input  logic [tmbs_pkg::WW-1:0]   dirt,
    input  logic [tmbs_pkg::WW-1:0]   rock,
    input  tmbs_pkg::side_t           w_side,
    output logic                      d_vld,
    output tmbs_pkg::div_t            d_div,
    output tmbs_pkg::side_t           d_side
);

    logic                        dirt_first;
    tmbs_pkg::layer_t            p1, q1;
    logic [tmbs_pkg::WW-1:0]     wp1, wq1;
    logic [tmbs_pkg::WW-1:0]     wp_next, ws_next;
    tmbs_pkg::side_t             side_a_next;

    logic                        a_vld_reg;
    logic [tmbs_pkg::WW-1:0]     a_wp_reg, a_ws_reg;
    tmbs_pkg::side_t             a_side_reg;

    // grass starts primary; dirt then rock take over only when strictly larger
    always_comb
    begin
        dirt_first = dirt > grass;
        p1  = dirt_first ? tmbs_pkg::LAYER_DIRT  : tmbs_pkg::LAYER_GRASS;
        q1  = dirt_first ? tmbs_pkg::LAYER_GRASS : tmbs_pkg::LAYER_DIRT;
        wp1 = dirt_first ? dirt  : grass;
        wq1 = dirt_first ? grass : dirt;

        side_a_next = w_side;
        if (rock > wp1)
        begin
            side_a_next.p = tmbs_pkg::LAYER_ROCK;
            side_a_next.q = p1;
            wp_next       = rock;
            ws_next       = wp1;
        end
        else if (rock > wq1)
        begin
            side_a_next.p = p1;
            side_a_next.q = tmbs_pkg::LAYER_ROCK;
            wp_next       = wp1;
            ws_next       = rock;
        end
        else
        begin
            side_a_next.p = p1;
            side_a_next.q = q1;
            wp_next       = wp1;
            ws_next       = wq1;
        end
    end

    logic [17:0]                 sum_w, den;
    tmbs_pkg::div_t              div_next;

    logic                        b_vld_reg;
    tmbs_pkg::div_t              b_div_reg;
    tmbs_pkg::side_t             b_side_reg;

    // share = (wp*510 + d) / (2d); divisor kept pre-shifted by the 8 quotient bits
    always_comb
    begin
        sum_w        = 18'(a_wp_reg) + 18'(a_ws_reg);
        den          = (sum_w < tmbs_pkg::D_MIN) ? tmbs_pkg::D_MIN : sum_w;
        div_next.rem = 27'({a_wp_reg, 9'b0}) - 27'({a_wp_reg, 1'b0}) + 27'(den);
        div_next.dsh = {den, 8'b0};
        div_next.quo = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= w_vld;
            b_vld_reg <= a_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_wp_reg   <= wp_next;
        a_ws_reg   <= ws_next;
        a_side_reg <= side_a_next;
        b_div_reg  <= div_next;
        b_side_reg <= a_side_reg;
    end

    assign d_vld  = b_vld_reg;
    assign d_div  = b_div_reg;
    assign d_side = b_side_reg;

endmodule

@@ sv/tmbs_div_stage.sv @@
// One stage of the restoring share divider: two quotient bits per stage.
// Depends on tmbs_pkg.
module tmbs_div_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  tmbs_pkg::div_t    in_div,
    input  tmbs_pkg::side_t   in_side,
    output logic              out_vld,
    output tmbs_pkg::div_t    out_div,
    output tmbs_pkg::side_t   out_side
);

    logic [tmbs_pkg::REM_W-1:0] rem_mid, rem_end;
    logic                       bit_hi, bit_lo;
    tmbs_pkg::div_t             div_next;

    logic                       vld_reg;
    tmbs_pkg::div_t             div_reg;
    tmbs_pkg::side_t            side_reg;

    // remainder stays below the shifted divisor, so doubling it never overflows
    always_comb
    begin
        bit_hi  = in_div.rem >= 27'(in_div.dsh);
        rem_mid = bit_hi ? (in_div.rem - 27'(in_div.dsh)) : in_div.rem;
        rem_mid = {rem_mid[tmbs_pkg::REM_W-2:0], 1'b0};

        bit_lo  = rem_mid >= 27'(in_div.dsh);
        rem_end = bit_lo ? (rem_mid - 27'(in_div.dsh)) : rem_mid;

        div_next.rem = {rem_end[tmbs_pkg::REM_W-2:0], 1'b0};
        div_next.dsh = in_div.dsh;
        div_next.quo = {in_div.quo[5:0], bit_hi, bit_lo};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= in_vld;
    end

    always_ff @(posedge clk)
    begin
        div_reg  <= div_next;
        side_reg <= in_side;
    end

    assign out_vld  = vld_reg;
    assign out_div  = div_reg;
    assign out_side = side_reg;

endmodule

@@ sv/terrain_material_blend_select.sv @@
// Terrain material blend select: top level, sea level register and output stage.
// Each item runs through the weight, select and divider stages and the output register; done is registered.
// Throughput: one item per cycle; busy never rises, results cannot be held off.
// Reset clears the pipeline valid bits and sets sea level to zero.
// Depends on tmbs_pkg, tmbs_weights, tmbs_select and tmbs_div_stage.
module terrain_material_blend_select
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [23:0] height,
    input  logic signed [15:0] slope,
    input  logic [7:0]         edit_index_first,
    input  logic [7:0]         edit_index_second,
    input  logic [7:0]         edit_weight,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [23:0]        cfg_data,
    output logic               done,
    output logic [1:0]         primary_layer,
    output logic [1:0]         secondary_layer,
    output logic [7:0]         primary_weight
);

    logic signed [23:0]       sea_level_reg;

    logic                     w_vld;
    logic [tmbs_pkg::WW-1:0]  grass, dirt, rock;
    tmbs_pkg::side_t          w_side;

    logic                     dv [0:4];
    tmbs_pkg::div_t           dd [0:4];
    tmbs_pkg::side_t          ds [0:4];

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sea_level_reg <= '0;
        else if (cfg_valid && cfg_ready)
            sea_level_reg <= cfg_data;
    end

    tmbs_weights u_weights
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_vld            (start && !busy),
        .height            (height),
        .slope             (slope),
        .sea_level         (sea_level_reg),
        .edit_index_first  (edit_index_first),
        .edit_index_second (edit_index_second),
        .edit_weight       (edit_weight),
        .w_vld             (w_vld),
        .grass             (grass),
        .dirt              (dirt),
        .rock              (rock),
        .w_side            (w_side)
    );

    tmbs_select u_select
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .w_vld  (w_vld),
        .grass  (grass),
        .dirt   (dirt),
        .rock   (rock),
        .w_side (w_side),
        .d_vld  (dv[0]),
        .d_div  (dd[0]),
        .d_side (ds[0])
    );

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        tmbs_div_stage u_div
        (
            .clk      (clk),
            .rst_n    (rst_n),
            .in_vld   (dv[i]),
            .in_div   (dd[i]),
            .in_side  (ds[i]),
            .out_vld  (dv[i+1]),
            .out_div  (dd[i+1]),
            .out_side (ds[i+1])
        );
    end

    function automatic tmbs_pkg::layer_t edit_layer(input logic [7:0] idx);
        tmbs_pkg::layer_t lay;
        if (idx > 8'd4)
            lay = tmbs_pkg::LAYER_SAND;
        else
            lay = tmbs_pkg::layer_t'(idx[1:0] - 2'd1);
        return lay;
    endfunction

    tmbs_pkg::side_t          fs;
    logic [7:0]               share;
    tmbs_pkg::layer_t         dom;
    tmbs_pkg::layer_t         p_next, q_next;
    logic [7:0]               pw_next;

    logic                     done_reg;
    tmbs_pkg::layer_t         p_reg, q_reg;
    logic [7:0]               pw_reg;

    always_comb
    begin
        fs    = ds[4];
        share = dd[4].quo;
        dom   = (share >= tmbs_pkg::DOM_MIN) ? fs.p : fs.q;

        p_next  = fs.p;
        q_next  = fs.q;
        pw_next = share;
        if (fs.e1 == 8'd0 && fs.e2 == 8'd0)
        begin
            if (fs.sand_hit)
            begin
                p_next  = tmbs_pkg::LAYER_SAND;
                q_next  = tmbs_pkg::LAYER_DIRT;
                pw_next = fs.sand_pw;
            end
        end
        else
        begin
            p_next  = (fs.e1 != 8'd0) ? edit_layer(fs.e1) : dom;
            q_next  = (fs.e2 != 8'd0) ? edit_layer(fs.e2) : dom;
            pw_next = fs.ew;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= dv[4];
    end

    always_ff @(posedge clk)
    begin
        p_reg  <= p_next;
        q_reg  <= q_next;
        pw_reg <= pw_next;
    end

    assign done            = done_reg;
    assign primary_layer   = p_reg;
    assign secondary_layer = q_reg;
    assign primary_weight  = pw_reg;

endmodule

@@ tb/sv/tb_terrain_material_blend_select.sv @@
`timescale 1ns / 1ps
// Testbench for terrain_material_blend_select: directed and random terrain points
// checked against an in-bench blend predictor. Depends on tmbs_pkg and the RTL top.
module tb_terrain_material_blend_select;

    localparam longint UNIT         = 65536;
    localparam longint STEEP_KNEE   = 144179;
    localparam longint HIGH_START   = 8704;
    localparam longint GRASS_START  = 768;
    localparam longint SAND_TOP     = 512;
    localparam longint SAND_FLOOR   = 131;
    localparam longint SHARE_FLOOR  = 7;
    localparam longint DOM_LIMIT    = 128;
    localparam int     PIPE_LATENCY = 10;
    localparam int     DRAIN_LIMIT  = 1000;
    localparam int     IDLE_NONE    = 0;
    localparam int     IDLE_HEAVY   = 88;
    localparam int     IDLE_LIGHT   = 11;

    typedef struct packed {
        tmbs_pkg::layer_t primary;
        tmbs_pkg::layer_t secondary;
        logic [7:0]       weight;
    } blend_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [23:0] height = '0;
    logic signed [15:0] slope = '0;
    logic [7:0]         edit_index_first = '0;
    logic [7:0]         edit_index_second = '0;
    logic [7:0]         edit_weight = '0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [23:0]        cfg_data = '0;
    logic               done;
    logic [1:0]         primary_layer;
    logic [1:0]         secondary_layer;
    logic [7:0]         primary_weight;

    logic signed [23:0] sea_level_model = '0;
    blend_t             expected_blends[$];
    int                 fault_count = 0;
    int                 idle_pct = IDLE_NONE;

    terrain_material_blend_select i_dut
    (
        .clk               (clk),
        .rst_n             (rst_n),
        .start             (start),
        .busy              (busy),
        .height            (height),
        .slope             (slope),
        .edit_index_first  (edit_index_first),
        .edit_index_second (edit_index_second),
        .edit_weight       (edit_weight),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .done              (done),
        .primary_layer     (primary_layer),
        .secondary_layer   (secondary_layer),
        .primary_weight    (primary_weight)
    );

    always #5 clk = ~clk;

    function automatic longint clamp_unit(input longint v);
        if (v < 0)
            return 0;
        if (v > UNIT)
            return UNIT;
        return v;
    endfunction

    function automatic longint round_mul(input longint a, input longint b);
        return (a * b + 32768) >> 16;
    endfunction

    function automatic tmbs_pkg::layer_t edit_layer(input logic [7:0] idx);
        if (idx - 1 > 3)
            return tmbs_pkg::LAYER_SAND;
        return tmbs_pkg::layer_t'(idx[1:0] - 2'd1);
    endfunction

    function automatic blend_t predict_blend(input logic signed [23:0] h,
                                             input logic signed [15:0] s,
                                             input logic [7:0] e1,
                                             input logic [7:0] e2,
                                             input logic [7:0] ew);
        longint hv, sv, sl, steep, high_w, rock, gh, nr, ga, d, share, sand;
        longint w[4];
        tmbs_pkg::layer_t p, q, cand, dom;
        blend_t r;
        hv = h;
        sv = s;
        sl = sea_level_model;
        steep = UNIT - clamp_unit(16 * sv - STEEP_KNEE);
        high_w = clamp_unit(((hv - HIGH_START) * 512) / 25);
        rock = (steep > high_w) ? steep : high_w;
        gh = clamp_unit((hv - sl - GRASS_START) * 32);
        nr = UNIT - rock;
        ga = round_mul(nr, gh);
        w[tmbs_pkg::LAYER_GRASS] = round_mul(ga, nr);
        w[tmbs_pkg::LAYER_DIRT]  = round_mul(UNIT - ga, nr);
        w[tmbs_pkg::LAYER_ROCK]  = rock;
        w[tmbs_pkg::LAYER_SAND]  = 0;
        p = tmbs_pkg::LAYER_GRASS;
        q = tmbs_pkg::LAYER_DIRT;
        // dirt, then rock; ties keep the earlier layer
        for (int k = 1; k <= 2; k++)
        begin
            cand = tmbs_pkg::layer_t'(2'(k));
            if (w[cand] > w[p])
            begin
                q = p;
                p = cand;
            end
            else if (cand != p && w[cand] > w[q])
                q = cand;
        end
        d = w[p] + w[q];
        if (d < SHARE_FLOOR)
            d = SHARE_FLOOR;
        share = (w[p] * 510 + d) / (2 * d);
        if (share > 255)
            share = 255;
        if (e1 == 0 && e2 == 0)
        begin
            sand = clamp_unit((sl + SAND_TOP - hv) * 128);
            if (sand > SAND_FLOOR)
            begin
                p = tmbs_pkg::LAYER_SAND;
                q = tmbs_pkg::LAYER_DIRT;
                share = (sand * 255 + 32768) >> 16;
                if (share > 255)
                    share = 255;
            end
        end
        else
        begin
            dom = (share >= DOM_LIMIT) ? p : q;
            p = (e1 != 0) ? edit_layer(e1) : dom;
            q = (e2 != 0) ? edit_layer(e2) : dom;
            share = ew;
        end
        r.primary = p;
        r.secondary = q;
        r.weight = share[7:0];
        return r;
    endfunction

    // one point transfer; start stays high for a back-to-back point
    task automatic send_point(input logic signed [23:0] h, input logic signed [15:0] s,
                              input logic [7:0] e1, input logic [7:0] e2,
                              input logic [7:0] ew);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start             <= 1'b1;
        height            <= h;
        slope             <= s;
        edit_index_first  <= e1;
        edit_index_second <= e2;
        edit_weight       <= ew;
        do
            @(posedge clk);
        while (busy);
        expected_blends.push_back(predict_blend(h, s, e1, e2, ew));
    endtask

    task automatic send_random_point();
        longint hv;
        logic signed [15:0] s;
        logic [7:0] e1, e2, ew;
        int pick;
        pick = $urandom_range(9);
        if (pick < 4)
            hv = longint'(sea_level_model) + $urandom_range(3000) - 1000;
        else if (pick < 7)
            hv = HIGH_START + $urandom_range(4500) - 500;
        else if (pick < 8)
            hv = longint'($urandom);
        else
            hv = longint'($urandom_range(40000)) - 20000;
        pick = $urandom_range(9);
        if (pick < 7)
            s = 16'($urandom_range(32768) - 16384);
        else if (pick < 9)
            s = 16'($urandom_range(13600, 8500));
        else
            s = 16'($urandom);
        ew = 8'($urandom);
        pick = $urandom_range(9);
        if (pick < 5)
        begin
            e1 = '0;
            e2 = '0;
        end
        else if (pick < 6)
        begin
            e1 = 8'($urandom);
            e2 = 8'($urandom);
        end
        else
        begin
            e1 = 8'($urandom_range(5));
            e2 = 8'($urandom_range(5));
        end
        send_point(hv[23:0], s, e1, e2, ew);
    endtask

    task automatic wait_blends_drained();
        int n;
        n = 0;
        start <= 1'b0;
        do
        begin
            @(posedge clk);
            n++;
        end
        while (expected_blends.size() != 0 && n < DRAIN_LIMIT);
    endtask

    task automatic write_sea_level(input logic signed [23:0] v);
        wait_blends_drained();
        repeat (PIPE_LATENCY) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        sea_level_model = v;
        cfg_valid <= 1'b0;
    endtask

    // sea level at its reset value of zero
    task automatic test_special_cases();
        idle_pct = IDLE_NONE;
        send_point(24'sd5000, 16'sd0, 8'd0, 8'd0, 8'd0);          // full rock
        send_point(24'sd5000, 16'sd16384, 8'd0, 8'd0, 8'd0);      // full grass
        send_point(24'sd1792, 16'sd16384, 8'd0, 8'd0, 8'd0);      // grass/dirt tie
        send_point(24'sd10304, 16'sd16384, 8'd0, 8'd0, 8'd0);     // high band, tie below rock
        send_point(24'sd8388607, -16'sd32768, 8'd0, 8'd0, 8'd0);
        send_point(-24'sd8388608, 16'sd32767, 8'd0, 8'd0, 8'd0);  // deep under sea
        send_point(24'sd509, 16'sd16384, 8'd0, 8'd0, 8'd0);
        send_point(24'sd510, 16'sd16384, 8'd0, 8'd0, 8'd0);       // just past the sand floor
        send_point(24'sd511, 16'sd16384, 8'd0, 8'd0, 8'd0);       // just below the sand floor
        send_point(24'sd3000, -16'sd16384, 8'd0, 8'd0, 8'd0);
        send_point(24'sd3000, 16'sd9011, 8'd0, 8'd0, 8'd0);       // steepness knee
        send_point(24'sd3000, 16'sd9012, 8'd0, 8'd0, 8'd0);
        send_point(24'sd3000, 16'sd13107, 8'd0, 8'd0, 8'd0);
        send_point(24'sd3000, 16'sd13108, 8'd0, 8'd0, 8'd0);
        send_point(24'sd1792, 16'sd16384, 8'd3, 8'd0, 8'd0);      // edit, secondary from tie
        send_point(24'sd5000, 16'sd0, 8'd1, 8'd0, 8'd255);
        send_point(24'sd5000, 16'sd16384, 8'd0, 8'd2, 8'd255);
        send_point(24'sd2000, 16'sd12000, 8'd4, 8'd3, 8'd77);
        send_point(24'sd2000, 16'sd12000, 8'd5, 8'd255, 8'd128);  // indices capped
        send_point(24'sd0, 16'sd16384, 8'd255, 8'd1, 8'd1);       // edit beats sand
        send_point(24'sd0, 16'sd16384, 8'd0, 8'd0, 8'd255);       // sand, weight ignored
        send_point(24'sd12000, 16'sd10000, 8'd0, 8'd4, 8'd170);
        wait_blends_drained();
    endtask

    task automatic test_sea_level_extremes();
        idle_pct = IDLE_LIGHT;
        write_sea_level(24'sd8388607);
        repeat (40) send_random_point();
        send_point(24'sd8388607, 16'sd16384, 8'd0, 8'd0, 8'd0);
        write_sea_level(-24'sd8388608);
        repeat (40) send_random_point();
        send_point(-24'sd8388608, 16'sd16384, 8'd0, 8'd0, 8'd0);
        wait_blends_drained();
    endtask

    task automatic test_random_blend(input logic signed [23:0] sea, input int idle,
                                     input int count);
        write_sea_level(sea);
        idle_pct = idle;
        repeat (count) send_random_point();
        wait_blends_drained();
    endtask

    always @(posedge clk)
    begin
        blend_t want;
        if (rst_n && done)
        begin
            if (expected_blends.size() == 0)
            begin
                $error("result with no pending point");
                fault_count++;
            end
            else
            begin
                want = expected_blends.pop_front();
                if (primary_layer !== want.primary)
                begin
                    $error("primary_layer: expected %0d, got %0d", want.primary, primary_layer);
                    fault_count++;
                end
                if (secondary_layer !== want.secondary)
                begin
                    $error("secondary_layer: expected %0d, got %0d", want.secondary,
                           secondary_layer);
                    fault_count++;
                end
                if (primary_weight !== want.weight)
                begin
                    $error("primary_weight: expected %0d, got %0d", want.weight,
                           primary_weight);
                    fault_count++;
                end
            end
        end
    end

    initial
    begin
        #1000000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_special_cases();
        test_sea_level_extremes();
        test_random_blend(24'sd0, IDLE_NONE, 300);
        test_random_blend(24'sd2560, IDLE_HEAVY, 250);
        test_random_blend(24'($urandom_range(40000) - 20000), IDLE_LIGHT, 250);
        test_random_blend(-24'sd3000, IDLE_NONE, 200);
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        if (expected_blends.size() != 0)
        begin
            $error("%0d results never arrived", expected_blends.size());
            fault_count++;
        end
        if (fault_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

@@ sim.f @@
sv/tmbs_pkg.sv
sv/tmbs_weights.sv
sv/tmbs_select.sv
sv/tmbs_div_stage.sv
sv/terrain_material_blend_select.sv
tb/sv/tb_terrain_material_blend_select.sv
